// ===== hw/rtl/matrix_keypad_scanner_defines.svh =====
// Assertion macros for the keypad scanner.
// Each check is sampled on clk and is off while rst_n is low.
`ifndef MATRIX_KEYPAD_SCANNER_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define KPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad scanner check failed");
`define KPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad scanner check failed");
`else
`define KPS_ASSERT_SAME(label, ante, cons)
`define KPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/kps_pkg.sv =====
`default_nettype none
package kps_pkg;

  localparam int DefNumColumns = 6;
  localparam int DefNumRows    = 4;

  // operation codes on in_op
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_HOLD_TICKS  = 2'd0;
  localparam logic [1:0] CFG_CLICK_PAUSE = 2'd1;
  localparam logic [1:0] CFG_HOLD_PAUSE  = 2'd2;
  localparam logic [1:0] CFG_START_PAUSE = 2'd3;

  // column drive codes
  localparam logic [2:0] DRIVE_ALL = 3'd6;
  localparam logic [2:0] DRIVE_OFF = 3'd7;

  // event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CLICK = 2'd1;
  localparam logic [1:0] EV_HOLD  = 2'd2;

  typedef struct packed {
    logic [7:0] hold_ticks;
    logic [7:0] click_pause;
    logic [7:0] hold_pause;
    logic [7:0] start_pause;
  } cfg_t;

  typedef struct packed {
    logic [2:0] col_drive;
    logic [7:0] key_code;
    logic       stay_boot;
    logic       held_on_start;
    logic [1:0] event_res;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/kps_cfg.sv =====
`default_nettype none
module kps_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_addr,
  input  wire logic [7:0]    cfg_wdata,
  output kps_pkg::cfg_t      cfg
);
  import kps_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks  <= 8'd40;
      cfg_r.click_pause <= 8'd10;
      cfg_r.hold_pause  <= 8'd50;
      cfg_r.start_pause <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HOLD_TICKS:  cfg_r.hold_ticks  <= cfg_wdata;
        CFG_CLICK_PAUSE: cfg_r.click_pause <= cfg_wdata;
        CFG_HOLD_PAUSE:  cfg_r.hold_pause  <= cfg_wdata;
        CFG_START_PAUSE: cfg_r.start_pause <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hw/rtl/kps_core.sv =====
`default_nettype none
module kps_core #(
  parameter int NUM_COLUMNS = kps_pkg::DefNumColumns,
  parameter int NUM_ROWS    = kps_pkg::DefNumRows
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [1:0]    op,
  input  wire logic [3:0]    rows_n,
  input  kps_pkg::cfg_t      cfg,
  output kps_pkg::res_t      res
);
  import kps_pkg::*;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_SCAN       = 3'd1;
  localparam logic [2:0] PH_DEBOUNCE   = 3'd2;
  localparam logic [2:0] PH_PAUSE      = 3'd3;
  localparam logic [2:0] PH_START1     = 3'd4;
  localparam logic [2:0] PH_START_WAIT = 3'd5;
  localparam logic [2:0] PH_START2     = 3'd6;

  localparam logic [3:0] LastCol = 4'(NUM_COLUMNS);

  logic [2:0] phase_r, phase_nxt;
  logic [2:0] column_r, column_nxt;
  logic [2:0] key_row_r, key_row_nxt;
  logic [7:0] tick_count_r, tick_count_nxt;
  logic [2:0] last_col_r, last_col_nxt;
  logic [2:0] last_row_r, last_row_nxt;
  logic       boot_flag_r, boot_flag_nxt;
  logic       start_found_r, start_found_nxt;
  logic [1:0] ev;
  logic [2:0] row_id;
  logic [7:0] tc_inc;
  logic [7:0] tc_dec;

  // lowest low row wins: walk from the top down so the last hit is the lowest
  always_comb begin
    row_id = 3'd0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (!rows_n[r]) begin
        row_id = 3'(r + 1);
      end
    end
  end

  assign tc_inc = tick_count_r + 8'd1;
  assign tc_dec = tick_count_r - 8'd1;

  always_comb begin
    phase_nxt       = phase_r;
    column_nxt      = column_r;
    key_row_nxt     = key_row_r;
    tick_count_nxt  = tick_count_r;
    last_col_nxt    = last_col_r;
    last_row_nxt    = last_row_r;
    boot_flag_nxt   = boot_flag_r;
    start_found_nxt = start_found_r;
    ev              = EV_NONE;
    case (op)
      OP_TICK: begin
        case (phase_r)
          PH_SCAN: begin
            if (row_id != 3'd0) begin
              key_row_nxt    = row_id;
              tick_count_nxt = 8'd0;
              phase_nxt      = PH_DEBOUNCE;
            end else if (({1'b0, column_r} + 4'd1) >= LastCol) begin
              column_nxt = 3'd0;
              phase_nxt  = PH_IDLE;
            end else begin
              column_nxt = column_r + 3'd1;
            end
          end
          PH_DEBOUNCE: begin
            if (row_id != key_row_r) begin
              last_col_nxt   = column_r + 3'd1;
              last_row_nxt   = key_row_r;
              ev             = EV_CLICK;
              tick_count_nxt = cfg.click_pause;
              phase_nxt      = (cfg.click_pause == 8'd0) ? PH_IDLE : PH_PAUSE;
            end else begin
              tick_count_nxt = tc_inc;
              if (tc_inc >= cfg.hold_ticks) begin
                if (column_r == 3'd0 && key_row_r == 3'd4) begin
                  boot_flag_nxt = 1'b1;
                end
                if (column_r == 3'd4 && key_row_r == 3'd3) begin
                  boot_flag_nxt = 1'b0;
                end
                ev             = EV_HOLD;
                tick_count_nxt = cfg.hold_pause;
                phase_nxt      = (cfg.hold_pause == 8'd0) ? PH_IDLE : PH_PAUSE;
              end
            end
          end
          PH_PAUSE: begin
            tick_count_nxt = tc_dec;
            if (tc_dec == 8'd0) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_START1: begin
            if (row_id == 3'd3) begin
              if (cfg.start_pause == 8'd0) begin
                phase_nxt = PH_START2;
              end else begin
                tick_count_nxt = cfg.start_pause;
                phase_nxt      = PH_START_WAIT;
              end
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_START_WAIT: begin
            tick_count_nxt = tc_dec;
            if (tc_dec == 8'd0) begin
              phase_nxt = PH_START2;
            end
          end
          PH_START2: begin
            if (row_id == 3'd3) begin
              start_found_nxt = 1'b1;
              boot_flag_nxt   = 1'b1;
            end
            phase_nxt = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
            if (row_id != 3'd0) begin
              column_nxt = 3'd0;
              phase_nxt  = PH_SCAN;
            end
          end
        endcase
      end
      OP_CLEAR: begin
        last_col_nxt = 3'd0;
        last_row_nxt = 3'd0;
      end
      OP_START: begin
        start_found_nxt = 1'b0;
        tick_count_nxt  = 8'd0;
        phase_nxt       = PH_START1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      column_r      <= 3'd0;
      key_row_r     <= 3'd0;
      tick_count_r  <= 8'd0;
      last_col_r    <= 3'd0;
      last_row_r    <= 3'd0;
      boot_flag_r   <= 1'b0;
      start_found_r <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      column_r      <= column_nxt;
      key_row_r     <= key_row_nxt;
      tick_count_r  <= tick_count_nxt;
      last_col_r    <= last_col_nxt;
      last_row_r    <= last_row_nxt;
      boot_flag_r   <= boot_flag_nxt;
      start_found_r <= start_found_nxt;
    end
  end

  always_comb begin
    case (phase_nxt) inside
      PH_SCAN, PH_DEBOUNCE:              res.col_drive = column_nxt;
      PH_PAUSE:                          res.col_drive = DRIVE_OFF;
      PH_START1, PH_START_WAIT, PH_START2: res.col_drive = 3'd0;
      default:                           res.col_drive = DRIVE_ALL;
    endcase
  end

  assign res.key_code      = {1'b0, last_col_nxt, 1'b0, last_row_nxt};
  assign res.stay_boot     = boot_flag_nxt;
  assign res.held_on_start = start_found_nxt;
  assign res.event_res     = ev;

endmodule
`default_nettype wire

// ===== hw/rtl/kps_outreg.sv =====
`default_nettype none
module kps_outreg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  kps_pkg::res_t      res,
  input  wire logic          out_stall,
  output logic               out_valid,
  output kps_pkg::res_t      out_res
);
  import kps_pkg::*;

  logic valid_r;
  res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/matrix_keypad_scanner.sv =====
// Matrix keypad scanner with debounce, one step per 10 ms tick.
// Input channel (in_valid / in_stall): in_op selects a tick carrying the row
//   sample in_rows_n (active low), a key-code clear, or the start-up boot-key
//   check. in_rows_n must be sampled under the previous out_col_drive.
// Result channel (out_valid / out_stall): one result per input transfer with
//   the column drive for the next sample, the last clicked key code, the
//   stay-in-boot and held-on-start flags, and the click/hold event.
// Output: the result is registered and presented in the cycle after its input transfer.
// Throughput: one transfer per cycle while in_stall is low; the state update is a single pass of
//   logic between the state registers and the result register.
// Stall: while a result waits under out_stall, in_stall is raised and the
//   result holds; a result taken in the same cycle frees the slot at once.
// Reset (rst_n low, synchronous): idle with all columns driven, flags and
//   key code cleared, configuration back to 40 / 10 / 50 / 5.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 hold_ticks,
//   1 click_pause, 2 hold_pause, 3 start_pause); write only while idle.
`default_nettype none
`include "matrix_keypad_scanner_defines.svh"
module matrix_keypad_scanner #(
  parameter int NUM_COLUMNS = kps_pkg::DefNumColumns,
  parameter int NUM_ROWS    = kps_pkg::DefNumRows
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_op,
  input  wire logic [3:0] in_rows_n,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_col_drive,
  output logic [7:0]      out_key_code,
  output logic            out_stay_boot,
  output logic            out_held_on_start,
  output logic [1:0]      out_event_res,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [7:0] cfg_wdata
);
  import kps_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic in_accept;

  // hold the input only while a finished result still waits downstream
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  kps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // advance the scan state once per accepted transfer
  kps_core #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .op     (in_op),
    .rows_n (in_rows_n),
    .cfg    (cfg),
    .res    (res)
  );

  // result register: load on transfer, drop valid once taken
  kps_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_col_drive     = out_res.col_drive;
  assign out_key_code      = out_res.key_code;
  assign out_stay_boot     = out_res.stay_boot;
  assign out_held_on_start = out_res.held_on_start;
  assign out_event_res     = out_res.event_res;

  `KPS_ASSERT_SAME(a_stall_needs_result, in_stall, out_valid)
  `KPS_ASSERT_NEXT(a_transfer_gives_result, in_accept, out_valid)
  `KPS_ASSERT_NEXT(a_flag_only_on_transfer, !in_accept, $stable(out_stay_boot))
  `KPS_ASSERT_SAME(a_event_code_legal, out_valid, out_event_res != 2'd3)

endmodule
`default_nettype wire

// ===== bench/matrix_keypad_scanner_test.sv =====
`timescale 1ns / 1ps

module matrix_keypad_scanner_test;
  import kps_pkg::*;

  localparam int NumCols     = DefNumColumns;
  localparam int NumRows     = DefNumRows;
  localparam int PhaseItems  = 48;
  localparam int NumPhases   = 8;
  localparam int LongHold    = 80;
  localparam int DrainLimit  = 5000;
  localparam int TimeoutNs   = 2_000_000;

  // op code 3 has no meaning; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // scanner phases as tracked by the predictor
  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SETTLE, ST_PAUSE, ST_BOOT_FIRST, ST_BOOT_WAIT, ST_BOOT_SECOND
  } scan_state_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one row of the directed table: either a transfer (code = op, val = rows)
  // or a register write (code = index, val = data); typed rows carry the
  // expected result written out by hand
  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] code;
    logic [7:0] val;
    logic       typed;
    res_t       want;
  } dir_row_t;

  localparam res_t NO_RES    = '0;
  localparam res_t IDLE_RES  = '{DRIVE_ALL, 8'h00, 1'b0, 1'b0, EV_NONE};
  localparam res_t BOOT_HOLD = '{DRIVE_ALL, 8'h00, 1'b1, 1'b0, EV_HOLD};
  localparam res_t BOOT_DROP = '{DRIVE_ALL, 8'h00, 1'b0, 1'b0, EV_HOLD};
  localparam res_t CLICK_11  = '{DRIVE_ALL, 8'h11, 1'b0, 1'b0, EV_CLICK};
  localparam res_t BOOT_SEEN = '{DRIVE_ALL, 8'h00, 1'b1, 1'b1, EV_NONE};

  localparam int DirLen = 25;
  localparam dir_row_t DirTab [DirLen] = '{
    // straight out of reset: all columns driven, nothing latched
    '{ROW_ITEM, OP_TICK,         8'h0F, 1'b1, IDLE_RES},
    // unused op: state untouched
    '{ROW_ITEM, OP_UNUSED,       8'h00, 1'b1, IDLE_RES},
    // zero hold count and zero pauses
    '{ROW_CFG,  CFG_HOLD_TICKS,  8'd0,  1'b0, NO_RES},
    '{ROW_CFG,  CFG_CLICK_PAUSE, 8'd0,  1'b0, NO_RES},
    '{ROW_CFG,  CFG_HOLD_PAUSE,  8'd0,  1'b0, NO_RES},
    '{ROW_CFG,  CFG_START_PAUSE, 8'd0,  1'b0, NO_RES},
    // column 1 row 4 held: sets the stay-in-boot flag
    '{ROW_ITEM, OP_TICK,         8'h07, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h07, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h07, 1'b1, BOOT_HOLD},
    // column 5 row 3 held: scan walks out to column 5, then clears the flag
    '{ROW_ITEM, OP_TICK,         8'h0B, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h0F, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h0F, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h0F, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h0F, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h0B, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h0B, 1'b1, BOOT_DROP},
    // row changes under debounce: a click on column 1 row 1
    '{ROW_ITEM, OP_TICK,         8'h0E, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h0E, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h0D, 1'b1, CLICK_11},
    '{ROW_ITEM, OP_CLEAR,        8'h00, 1'b0, NO_RES},
    // boot-key check started in the middle of a scan
    '{ROW_ITEM, OP_TICK,         8'h0B, 1'b0, NO_RES},
    '{ROW_ITEM, OP_START,        8'h00, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h0B, 1'b0, NO_RES},
    '{ROW_ITEM, OP_TICK,         8'h0B, 1'b1, BOOT_SEEN},
    // every row low at once
    '{ROW_ITEM, OP_TICK,         8'h00, 1'b0, NO_RES}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [1:0] in_op     = OP_TICK;
  logic [3:0] in_rows_n = 4'hF;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_col_drive;
  logic [7:0] out_key_code;
  logic       out_stay_boot;
  logic       out_held_on_start;
  logic [1:0] out_event_res;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_addr  = CFG_HOLD_TICKS;
  logic [7:0] cfg_wdata = 8'h00;

  // predictor state, at its reset values
  logic [7:0]  hold_ticks_r  = 8'd40;
  logic [7:0]  click_pause_r = 8'd10;
  logic [7:0]  hold_pause_r  = 8'd50;
  logic [7:0]  start_pause_r = 8'd5;
  scan_state_t scan_st       = ST_IDLE;
  logic [2:0]  scan_col      = 3'd0;
  logic [2:0]  key_row_id    = 3'd0;
  logic [7:0]  tick_cnt      = 8'd0;
  logic [2:0]  click_col     = 3'd0;
  logic [2:0]  click_row     = 3'd0;
  logic        boot_flag     = 1'b0;
  logic        boot_found    = 1'b0;

  // column drive the next row sample will be taken under
  logic [2:0]  drive_now     = DRIVE_ALL;

  // simulated keypad: one key down or none, for key_left more ticks
  logic        key_down      = 1'b0;
  logic [2:0]  key_col       = 3'd0;
  logic [1:0]  key_row_ix    = 2'd0;
  int          key_left      = 0;

  res_t        pending_res [$];
  int          mismatches    = 0;
  bit          quiet         = 1'b0;
  bit          long_hold_req = 1'b0;

  matrix_keypad_scanner u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_rows_n         (in_rows_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_col_drive     (out_col_drive),
    .out_key_code      (out_key_code),
    .out_stay_boot     (out_stay_boot),
    .out_held_on_start (out_held_on_start),
    .out_event_res     (out_event_res),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Park the scanner for len ticks, or drop straight back to idle.
  function automatic void enter_pause(logic [7:0] len);
    tick_cnt = len;
    scan_st  = (len == 8'd0) ? ST_IDLE : ST_PAUSE;
  endfunction

  // Advance the predicted scanner by one transfer and return its result.
  function automatic res_t step_scanner(logic [1:0] op, logic [3:0] rows_n);
    logic [2:0] id;
    logic [1:0] ev;
    res_t       r;
    // lowest low row wins; 0 means no row low
    id = 3'd0;
    for (int i = NumRows - 1; i >= 0; i--) begin
      if (!rows_n[i]) id = 3'(i + 1);
    end
    ev = EV_NONE;
    case (op)
      OP_TICK: begin
        case (scan_st)
          ST_SCAN: begin
            if (id != 3'd0) begin
              key_row_id = id;
              tick_cnt   = 8'd0;
              scan_st    = ST_SETTLE;
            end else if (int'(scan_col) + 1 >= NumCols) begin
              scan_col = 3'd0;
              scan_st  = ST_IDLE;
            end else begin
              scan_col = scan_col + 3'd1;
            end
          end
          ST_SETTLE: begin
            if (id != key_row_id) begin
              click_col = scan_col + 3'd1;
              click_row = key_row_id;
              ev        = EV_CLICK;
              enter_pause(click_pause_r);
            end else begin
              tick_cnt = tick_cnt + 8'd1;
              if (tick_cnt >= hold_ticks_r) begin
                if (scan_col == 3'd0 && key_row_id == 3'd4) boot_flag = 1'b1;
                if (scan_col == 3'd4 && key_row_id == 3'd3) boot_flag = 1'b0;
                ev = EV_HOLD;
                enter_pause(hold_pause_r);
              end
            end
          end
          ST_PAUSE: begin
            tick_cnt = tick_cnt - 8'd1;
            if (tick_cnt == 8'd0) scan_st = ST_IDLE;
          end
          ST_BOOT_FIRST: begin
            if (id == 3'd3) begin
              if (start_pause_r == 8'd0) begin
                scan_st = ST_BOOT_SECOND;
              end else begin
                tick_cnt = start_pause_r;
                scan_st  = ST_BOOT_WAIT;
              end
            end else begin
              scan_st = ST_IDLE;
            end
          end
          ST_BOOT_WAIT: begin
            tick_cnt = tick_cnt - 8'd1;
            if (tick_cnt == 8'd0) scan_st = ST_BOOT_SECOND;
          end
          ST_BOOT_SECOND: begin
            if (id == 3'd3) begin
              boot_found = 1'b1;
              boot_flag  = 1'b1;
            end
            scan_st = ST_IDLE;
          end
          default: begin
            scan_st = ST_IDLE;
            if (id != 3'd0) begin
              scan_col = 3'd0;
              scan_st  = ST_SCAN;
            end
          end
        endcase
      end
      OP_CLEAR: begin
        click_col = 3'd0;
        click_row = 3'd0;
      end
      OP_START: begin
        boot_found = 1'b0;
        tick_cnt   = 8'd0;
        scan_st    = ST_BOOT_FIRST;
      end
      default: ;
    endcase
    case (scan_st)
      ST_SCAN, ST_SETTLE:                        r.col_drive = scan_col;
      ST_PAUSE:                                  r.col_drive = DRIVE_OFF;
      ST_BOOT_FIRST, ST_BOOT_WAIT, ST_BOOT_SECOND: r.col_drive = 3'd0;
      default:                                   r.col_drive = DRIVE_ALL;
    endcase
    r.key_code      = {1'b0, click_col, 1'b0, click_row};
    r.stay_boot     = boot_flag;
    r.held_on_start = boot_found;
    r.event_res     = ev;
    return r;
  endfunction

  // Offer one transfer, after an optional idle burst, and return at the edge
  // that takes it. Valid stays high so a following item can chain directly.
  task automatic send_item(logic [1:0] op, logic [3:0] rows_n);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_rows_n <= rows_n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted result has been taken.
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_res.size() != 0 && waited < DrainLimit);
    if (pending_res.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_res.size()));
  endtask

  // Write one register and mirror it; the caller lowers cfg_we afterwards.
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_HOLD_TICKS:  hold_ticks_r  = val;
      CFG_CLICK_PAUSE: click_pause_r = val;
      CFG_HOLD_PAUSE:  hold_pause_r  = val;
      default:         start_pause_r = val;
    endcase
    @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request that
  // lets the output register fill and back-pressure the input.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LongHold;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (quiet && stall_left > 0 && stall_left < LongHold) stall_left = 0;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer, field by field, against the oldest prediction.
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_col_drive, out_key_code, out_stay_boot, out_held_on_start, out_event_res};
      if (pending_res.size() == 0) begin
        report_mismatch($sformatf("result %0h with nothing pending", got));
      end else begin
        want = pending_res.pop_front();
        if (got.col_drive != want.col_drive)
          report_mismatch($sformatf("col_drive %0d, want %0d", got.col_drive, want.col_drive));
        if (got.key_code != want.key_code)
          report_mismatch($sformatf("key_code %0h, want %0h", got.key_code, want.key_code));
        if (got.stay_boot != want.stay_boot)
          report_mismatch($sformatf("stay_boot %0d, want %0d", got.stay_boot, want.stay_boot));
        if (got.held_on_start != want.held_on_start)
          report_mismatch($sformatf("held_on_start %0d, want %0d",
                                    got.held_on_start, want.held_on_start));
        if (got.event_res != want.event_res)
          report_mismatch($sformatf("event_res %0d, want %0d", got.event_res, want.event_res));
      end
    end
  end

  initial begin : stimulus
    logic [1:0] op;
    logic [3:0] rows_n;
    logic [7:0] cfg_vals [4];
    res_t       pred;
    int         pick;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: register rows are grouped, so drain once before a group
    // and drop the write enable once after it.
    for (int i = 0; i < DirLen; i++) begin
      if (DirTab[i].kind == ROW_CFG) begin
        if (i == 0 || DirTab[i - 1].kind != ROW_CFG) wait_drained();
        write_reg(DirTab[i].code, DirTab[i].val);
        if (i + 1 == DirLen || DirTab[i + 1].kind != ROW_CFG) cfg_we <= 1'b0;
      end else begin
        // always advance the predictor, even where the row spells out its result
        pred = step_scanner(DirTab[i].code, DirTab[i].val[3:0]);
        pending_res.push_back(DirTab[i].typed ? DirTab[i].want : pred);
        drive_now = pred.col_drive;
        send_item(DirTab[i].code, DirTab[i].val[3:0]);
      end
    end

    // Random phases, each under its own register setting. Most ticks come
    // from the simulated keypad, answering the drive the block asked for, so
    // scans, clicks, holds and boot checks run to completion.
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      quiet = (ph == NumPhases - 1);
      case (ph)
        0:       cfg_vals = '{8'd40, 8'd10, 8'd50, 8'd5};
        1:       cfg_vals = '{8'd1, 8'd0, 8'd0, 8'd0};
        2:       cfg_vals = '{8'd255, 8'd255, 8'd255, 8'd255};
        3:       cfg_vals = '{8'd2, 8'd3, 8'd4, 8'd2};
        5:       cfg_vals = '{8'd0, 8'd1, 8'd1, 8'd1};
        7:       cfg_vals = '{8'd3, 8'd2, 8'd2, 8'd1};
        default: cfg_vals = '{8'($urandom_range(1, 8)), 8'($urandom_range(0, 6)),
                              8'($urandom_range(0, 6)), 8'($urandom_range(0, 4))};
      endcase
      for (int r = 0; r < 4; r++) write_reg(2'(r), cfg_vals[r]);
      cfg_we   <= 1'b0;
      key_down = 1'b0;
      key_left = 0;

      for (int n = 0; n < PhaseItems; n++) begin
        // hold off the receiver once while transfers keep coming
        if (ph == 3 && n == 8) long_hold_req = 1'b1;
        // pause the sender once per phase, but for the quiet last one, until the block has emptied
        if (n == PhaseItems / 2 && !quiet) wait_drained();

        pick   = $urandom_range(0, 99);
        rows_n = 4'($urandom);
        if (pick < 4) begin
          op = OP_CLEAR;
        end else if (pick < 8) begin
          op = OP_START;
          // half the time, press the boot key for a random stretch
          if (pick < 6) begin
            key_down   = 1'b1;
            key_col    = 3'd0;
            key_row_ix = 2'd2;
            key_left   = $urandom_range(1, int'(start_pause_r) + 4);
          end
        end else if (pick < 10) begin
          op = OP_UNUSED;
        end else begin
          op = OP_TICK;
          if (key_left == 0) begin
            key_down = ($urandom_range(0, 2) != 0);
            key_left = key_down ? $urandom_range(1, int'(hold_ticks_r) + 10)
                                : $urandom_range(1, 4);
            case ($urandom_range(0, 3))
              0: begin
                key_col    = 3'd0;
                key_row_ix = 2'd3;
              end
              1: begin
                key_col    = 3'd4;
                key_row_ix = 2'd2;
              end
              default: begin
                key_col    = 3'($urandom_range(0, NumCols - 1));
                key_row_ix = 2'($urandom_range(0, NumRows - 1));
              end
            endcase
          end
          key_left--;
          // below 20 the row sample stays pure noise
          if (pick >= 20) begin
            rows_n = 4'hF;
            if (key_down && (drive_now == DRIVE_ALL || drive_now == key_col))
              rows_n[key_row_ix] = 1'b0;
            // stray contacts pulling extra rows low
            if (pick < 26) rows_n = rows_n & 4'($urandom);
          end
        end

        pred = step_scanner(op, rows_n);
        pending_res.push_back(pred);
        drive_now = pred.col_drive;
        send_item(op, rows_n);
      end
    end

    wait_drained();
    // leave room for any stray result transfer to show up
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("matrix_keypad_scanner_test: done, clean");
    end else begin
      $display("matrix_keypad_scanner_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("matrix_keypad_scanner_test: done, errors");
    $finish;
  end

endmodule

// ===== matrix_keypad_scanner.f =====
+incdir+hw/rtl
hw/rtl/kps_pkg.sv
hw/rtl/kps_cfg.sv
hw/rtl/kps_core.sv
hw/rtl/kps_outreg.sv
hw/rtl/matrix_keypad_scanner.sv
bench/matrix_keypad_scanner_test.sv
